// ----- rtl/cdq_pkg.sv -----
// shared types and constants of the circular deque
package cdq_pkg;

	localparam int DATA_W    = 32;
	localparam int CNT_W     = 11;
	localparam int DEPTH_DEF = 1024;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

	// word index of a register, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		FN_PUSH_FRONT = 2'd0,
		FN_PUSH_BACK  = 2'd1,
		FN_POP_FRONT  = 2'd2,
		FN_POP_BACK   = 2'd3
	} func_e_t;

	typedef struct packed {
		logic             ok;
		logic             empty;
		logic             full;
		logic [CNT_W-1:0] count;
	} step_info_t;

endpackage

// ----- rtl/circular_deque_top.sv -----
// circular deque top level: config port, request pipeline and result register
//
//  channel   direction  handshake            payload
//  request   in         in_valid / in_stall  func, value
//  result    out        out_valid / out_stall ok, front_value, rear_value,
//                                            is_empty, is_full, count
//  config    in         apb psel / penable   capacity at byte address 0
//
// one request per cycle sustained while out_stall is low; the result reaches the
// output register through the read stage, set by the store's registered read port
// reset empties the deque and sets capacity to 1024; store contents are left
// as they are, no clearing pass
// out_stall holds the result register, then the read stage, then in_stall
// a capacity write empties the deque
module circular_deque_top import cdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               func,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     ok,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] rear_value,
	output logic                     is_empty,
	output logic                     is_full,
	output logic [CNT_W-1:0]         count
);

	localparam int IW = $clog2(DEPTH);

	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  cap_eff;
	logic              cfg_wr;
	logic              accept;
	logic              out_load;
	logic              we;
	logic [IW-1:0]     waddr, raddr_front, raddr_rear;
	logic [DATA_W-1:0] wdata, rdata_front, rdata_rear;
	step_info_t        info, info_s1;
	logic              valid_s1;
	logic              out_valid_q;
	step_info_t        out_info_q;
	logic [DATA_W-1:0] front_q, rear_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CNT_W-1:0];
		end
	end

	assign out_load = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_load;
	assign accept   = in_valid && !in_stall;

	cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (cfg_wr),
		.capacity    (cap_q),
		.step        (accept),
		.func        (func),
		.value       (value),
		.we          (we),
		.waddr       (waddr),
		.wdata       (wdata),
		.raddr_front (raddr_front),
		.raddr_rear  (raddr_rear),
		.info        (info),
		.cap_eff     (cap_eff)
	);

	cdq_store #(.DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (accept),
		.raddr_a (raddr_front),
		.raddr_b (raddr_rear),
		.rdata_a (rdata_front),
		.rdata_b (rdata_rear)
	);

	// read stage waits on the store's registered data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s1) begin
			out_info_q <= info_s1;
			front_q    <= info_s1.empty ? '1 : rdata_front;
			rear_q     <= info_s1.empty ? '1 : rdata_rear;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = out_info_q.ok;
	assign is_empty    = out_info_q.empty;
	assign is_full     = out_info_q.full;
	assign count       = out_info_q.count;
	assign front_value = front_q;
	assign rear_value  = rear_q;

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= cap_eff) && (is_full == (count == cap_eff)))
		else $error("result count outside capacity");

	a_empty_reads_minus_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> (front_value == -1) && (rear_value == -1)
			&& (count == '0))
		else $error("empty result with stale data");

	a_request_reaches_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request lost before the read stage");

	a_no_take_while_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && out_stall |-> !accept)
		else $error("request taken while result path is blocked");

endmodule

// ----- rtl/cdq_store.sv -----
// entry store: one write port, two registered read ports with write forwarding
module cdq_store import cdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [DATA_W-1:0]        rdata_a,
	output logic [DATA_W-1:0]        rdata_b
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_a_q;
	logic [DATA_W-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// a read of the entry written in the same cycle sees the new word
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a_q <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
			rdata_b_q <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// ----- rtl/cdq_ctrl.sv -----
// head, tail and count registers with the per-request update and store addressing
module cdq_ctrl import cdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  logic [CNT_W-1:0]         capacity,
	input  logic                     step,
	input  logic [1:0]               func,
	input  logic [DATA_W-1:0]        value,
	output logic                     we,
	output logic [$clog2(DEPTH)-1:0] waddr,
	output logic [DATA_W-1:0]        wdata,
	output logic [$clog2(DEPTH)-1:0] raddr_front,
	output logic [$clog2(DEPTH)-1:0] raddr_rear,
	output step_info_t               info,
	output logic [CNT_W-1:0]         cap_eff
);

	localparam int IW = $clog2(DEPTH);
	localparam int W  = ((IW > CNT_W) ? IW : CNT_W) + 1;
	localparam logic [31:0] DEPTH_L = 32'(DEPTH);

	logic [IW-1:0]    head_q, tail_q, head_n, tail_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             ok;
	logic             is_push;

	function automatic logic [IW-1:0] inc_wrap(logic [IW-1:0] i, logic [CNT_W-1:0] c);
		logic [W-1:0] n;
		n = W'(i) + W'(1);
		return (n >= W'(c)) ? '0 : IW'(n);
	endfunction

	function automatic logic [IW-1:0] dec_wrap(logic [IW-1:0] i, logic [CNT_W-1:0] c);
		return (i == '0 || W'(i) >= W'(c)) ? IW'(W'(c) - W'(1)) : i - IW'(1);
	endfunction

	// zero means one entry, and no more than the store holds
	always_comb begin
		if (capacity == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(capacity) > DEPTH_L) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = capacity;
		end
	end

	assign is_push = (func == FN_PUSH_FRONT) || (func == FN_PUSH_BACK);

	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		cnt_n  = cnt_q;
		ok     = 1'b0;
		we     = 1'b0;
		waddr  = head_q;
		wdata  = value;
		if (is_push) begin
			if (cnt_q < cap_eff) begin
				ok    = 1'b1;
				we    = step;
				cnt_n = cnt_q + CNT_W'(1);
				if (cnt_q == '0) begin
					// first entry always lands at index zero
					head_n = '0;
					waddr  = '0;
					tail_n = inc_wrap('0, cap_eff);
				end else if (func == FN_PUSH_FRONT) begin
					head_n = dec_wrap(head_q, cap_eff);
					waddr  = head_n;
				end else begin
					waddr  = tail_q;
					tail_n = inc_wrap(tail_q, cap_eff);
				end
			end
		end else if (cnt_q != '0) begin
			ok    = 1'b1;
			cnt_n = cnt_q - CNT_W'(1);
			if (cnt_n == '0) begin
				head_n = '0;
				tail_n = '0;
			end else if (func == FN_POP_FRONT) begin
				head_n = inc_wrap(head_q, cap_eff);
			end else begin
				tail_n = dec_wrap(tail_q, cap_eff);
			end
		end
		raddr_front = head_n;
		raddr_rear  = dec_wrap(tail_n, cap_eff);
		info.ok     = ok;
		info.empty  = (cnt_n == '0);
		info.full   = (cnt_n == cap_eff);
		info.count  = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (clear) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (step) begin
			head_q <= head_n;
			tail_q <= tail_n;
			cnt_q  <= cnt_n;
		end
	end

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the circular deque: directed table, then random phases
module tb;
	import cdq_pkg::*;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] fv;
		logic [DATA_W-1:0] rv;
		logic              empty;
		logic              full;
		logic [CNT_W-1:0]  cnt;
	} deque_res_t;

	typedef enum logic [1:0] {ROW_REQ, ROW_CHK, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		func_e_t           fn;
		logic [31:0]       data;
		deque_res_t        want;
	} dir_row_t;

	localparam deque_res_t RES_NONE    = '{1'b0, '1, '1, 1'b1, 1'b0, '0};
	localparam deque_res_t RES_DRAINED = '{1'b1, '1, '1, 1'b1, 1'b0, '0};
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int NUM_PHASES = 10;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_AW-1:0]        paddr = '0;
	logic [APB_DW-1:0]        pwdata = '0;
	logic [APB_DW-1:0]        prdata;
	logic                     pready;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               func = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     ok;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] rear_value;
	logic                     is_empty;
	logic                     is_full;
	logic [CNT_W-1:0]         count;

	circular_deque_top uut (.*);

	// deque shadow state
	logic [DATA_W-1:0] dq_mem [0:DEPTH_DEF-1];
	int                dq_head, dq_tail, dq_cnt;
	logic [CNT_W-1:0]  cap_raw;

	deque_res_t expq [$];
	dir_row_t   dir_tab [];
	int         err_cnt, n_req, n_res, n_cfg, n_refused, n_full;
	bit         send_idle, recv_idle, hold_pending;
	int         idle_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int eff_cap();
		int c;
		c = cap_raw;
		if (c == 0)
			c = 1;
		if (c > DEPTH_DEF)
			c = DEPTH_DEF;
		return c;
	endfunction

	function automatic int wrap_inc(int i, int c);
		return (i + 1 >= c) ? 0 : i + 1;
	endfunction

	function automatic int wrap_dec(int i, int c);
		return (i == 0 || i >= c) ? c - 1 : i - 1;
	endfunction

	function automatic deque_res_t deque_step(func_e_t fn, logic [DATA_W-1:0] v);
		deque_res_t r;
		int c;
		c = eff_cap();
		r.ok = 1'b0;
		if (fn == FN_PUSH_FRONT || fn == FN_PUSH_BACK) begin
			if (dq_cnt < c) begin
				if (dq_cnt == 0) begin
					dq_head = 0;
					dq_mem[0] = v;
					dq_tail = wrap_inc(0, c);
				end else if (fn == FN_PUSH_FRONT) begin
					dq_head = wrap_dec(dq_head, c);
					dq_mem[dq_head] = v;
				end else begin
					dq_mem[dq_tail] = v;
					dq_tail = wrap_inc(dq_tail, c);
				end
				dq_cnt++;
				r.ok = 1'b1;
			end
		end else if (dq_cnt != 0) begin
			dq_cnt--;
			if (dq_cnt == 0) begin
				dq_head = 0;
				dq_tail = 0;
			end else if (fn == FN_POP_FRONT) begin
				dq_head = wrap_inc(dq_head, c);
			end else begin
				dq_tail = wrap_dec(dq_tail, c);
			end
			r.ok = 1'b1;
		end
		r.fv = (dq_cnt != 0) ? dq_mem[dq_head] : '1;
		r.rv = (dq_cnt != 0) ? dq_mem[wrap_dec(dq_tail, c)] : '1;
		r.empty = (dq_cnt == 0);
		r.full = (dq_cnt == c);
		r.cnt = dq_cnt[CNT_W-1:0];
		return r;
	endfunction

	function automatic void cmp(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t %s: expected %h, got %h", $time, what, want, got);
		end
	endfunction

	// sender: random gap while send_idle, then hold the request until taken
	task automatic send_req(func_e_t fn, logic [DATA_W-1:0] v);
		int gap;
		gap = send_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic issue(func_e_t fn, logic [DATA_W-1:0] v, bit typed, deque_res_t want);
		deque_res_t got;
		send_req(fn, v);
		got = deque_step(fn, v);
		if (!got.ok)
			n_refused++;
		if (got.full)
			n_full++;
		expq.push_back(typed ? want : got);
		n_req++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expq.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write capacity over apb and read it back
	task automatic apply_capacity(logic [31:0] data);
		wait_idle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {REG_CAPACITY, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		cap_raw = data[CNT_W-1:0];
		dq_head = 0;
		dq_tail = 0;
		dq_cnt = 0;
		n_cfg++;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		cmp("capacity readback", {{(APB_DW-CNT_W){1'b0}}, cap_raw}, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// receiver: random stall before each result while recv_idle, one long hold on request
	initial begin : result_side
		int n;
		forever begin
			n = recv_idle ? $urandom_range(0, 8) : 0;
			if (hold_pending) begin
				n = HOLD_CYCLES;
				hold_pending = 1'b0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : result_check
		deque_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_res++;
			if (expq.size() == 0) begin
				err_cnt++;
				$display("%0t unexpected result: ok %b count %0d", $time, ok, count);
			end else begin
				want = expq.pop_front();
				cmp("ok", want.ok, ok);
				cmp("front_value", want.fv, front_value);
				cmp("rear_value", want.rv, rear_value);
				cmp("is_empty", want.empty, is_empty);
				cmp("is_full", want.full, is_full);
				cmp("count", want.cnt, count);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (psel && penable)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no progress, %0d results pending", $time, expq.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int               ph_cap [NUM_PHASES];
		int               ph_len [NUM_PHASES];
		int               c, pct, chunk;
		bit               fill, is_push, back;
		func_e_t          fn;
		logic [DATA_W-1:0] v;

		ph_cap = '{4, 1, 1024, 0, 2047, 0, 0, 0, 0, 0};
		ph_len = '{120, 80, 1100, 50, 80, 80, 80, 80, 80, 80};
		for (int p = 5; p < NUM_PHASES; p++)
			ph_cap[p] = $urandom_range(2, 40);

		dir_tab = '{
			'{ROW_CHK, FN_POP_FRONT, 32'h0, RES_NONE},
			'{ROW_CHK, FN_POP_BACK, 32'hFFFF_FFFF, RES_NONE},
			'{ROW_CHK, FN_PUSH_BACK, 32'h7FFF_FFFF,
				'{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 11'd1}},
			// push front from one entry wraps head to the top of the store
			'{ROW_CHK, FN_PUSH_FRONT, 32'h8000_0000,
				'{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 11'd2}},
			'{ROW_CHK, FN_PUSH_FRONT, 32'h0,
				'{1'b1, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b0, 11'd3}},
			'{ROW_CHK, FN_POP_BACK, 32'h0,
				'{1'b1, 32'h0, 32'h8000_0000, 1'b0, 1'b0, 11'd2}},
			'{ROW_CHK, FN_POP_FRONT, 32'h0,
				'{1'b1, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 11'd1}},
			'{ROW_CHK, FN_POP_FRONT, 32'h0, RES_DRAINED},
			'{ROW_REQ, FN_PUSH_BACK, 32'h1234_5678, RES_NONE},
			'{ROW_REQ, FN_PUSH_FRONT, 32'hFFFF_FFFF, RES_NONE},
			// capacity rewrite while holding entries empties the deque
			'{ROW_CFG, FN_PUSH_FRONT, 32'd1024, RES_NONE},
			'{ROW_CHK, FN_POP_BACK, 32'h0, RES_NONE},
			'{ROW_CFG, FN_PUSH_FRONT, 32'd1, RES_NONE},
			'{ROW_CHK, FN_PUSH_BACK, 32'h55AA_55AA,
				'{1'b1, 32'h55AA_55AA, 32'h55AA_55AA, 1'b0, 1'b1, 11'd1}},
			'{ROW_CHK, FN_PUSH_FRONT, 32'h1,
				'{1'b0, 32'h55AA_55AA, 32'h55AA_55AA, 1'b0, 1'b1, 11'd1}},
			'{ROW_CHK, FN_POP_BACK, 32'h0, RES_DRAINED},
			// zero capacity behaves as one
			'{ROW_CFG, FN_PUSH_FRONT, 32'd0, RES_NONE},
			'{ROW_CHK, FN_PUSH_FRONT, 32'hAAAA_AAAA,
				'{1'b1, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 1'b1, 11'd1}},
			'{ROW_CHK, FN_PUSH_BACK, 32'h2,
				'{1'b0, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 1'b1, 11'd1}},
			'{ROW_CFG, FN_PUSH_FRONT, 32'd2, RES_NONE},
			'{ROW_REQ, FN_PUSH_FRONT, 32'd7, RES_NONE},
			'{ROW_REQ, FN_PUSH_FRONT, 32'd8, RES_NONE},
			'{ROW_REQ, FN_PUSH_BACK, 32'd9, RES_NONE},
			'{ROW_REQ, FN_POP_BACK, 32'h0, RES_NONE},
			'{ROW_REQ, FN_PUSH_BACK, 32'd10, RES_NONE},
			'{ROW_REQ, FN_POP_FRONT, 32'h0, RES_NONE},
			// above the store size saturates
			'{ROW_CFG, FN_PUSH_FRONT, 32'd2047, RES_NONE},
			'{ROW_REQ, FN_PUSH_FRONT, 32'h0F0F_0F0F, RES_NONE},
			'{ROW_REQ, FN_PUSH_FRONT, 32'hF0F0_F0F0, RES_NONE},
			// upper write bits fall outside the register
			'{ROW_CFG, FN_PUSH_FRONT, 32'hFFFF_F805, RES_NONE},
			'{ROW_REQ, FN_PUSH_BACK, 32'd11, RES_NONE},
			'{ROW_REQ, FN_PUSH_BACK, 32'd12, RES_NONE},
			'{ROW_REQ, FN_POP_FRONT, 32'h0, RES_NONE}
		};

		cap_raw = CAP_RESET;
		dq_head = 0;
		dq_tail = 0;
		dq_cnt = 0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG)
				apply_capacity(dir_tab[i].data);
			else
				issue(dir_tab[i].fn, dir_tab[i].data, dir_tab[i].kind == ROW_CHK,
					dir_tab[i].want);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			apply_capacity(ph_cap[p]);
			c = eff_cap();
			fill = (ph_cap[p] == 1024);
			if (fill) begin
				// back-to-back requests while the result side holds off
				send_idle = 1'b0;
				recv_idle = 1'b0;
				hold_pending = 1'b1;
			end else begin
				send_idle = (p != 0) && ($urandom_range(0, 3) != 0);
				recv_idle = (p != 0) && ($urandom_range(0, 3) != 0);
			end
			chunk = 2 * c + 4;
			for (int k = 0; k < ph_len[p]; k++) begin
				if (fill && k < c + 6)
					pct = 100;
				else
					pct = ((k / chunk) % 2 == 0) ? 75 : 25;
				is_push = ($urandom_range(0, 99) < pct);
				back = $urandom_range(0, 1);
				if (is_push)
					fn = back ? FN_PUSH_BACK : FN_PUSH_FRONT;
				else
					fn = back ? FN_POP_BACK : FN_POP_FRONT;
				case ($urandom_range(0, 7))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h0;
					3: v = 32'hFFFF_FFFF;
					default: v = $urandom;
				endcase
				issue(fn, v, 1'b0, RES_NONE);
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("ran %0d requests (%0d refused, %0d ending full) over %0d capacity writes",
			n_req, n_refused, n_full, n_cfg);
		$display("checked %0d results, %0d mismatches", n_res, err_cnt);
		if (err_cnt == 0 && expq.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
